>>> sv/fully_associative_lru_tracker_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the LRU tracker
// Concurrent checks clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FULLY_ASSOCIATIVE_LRU_TRACKER_ASSERT_SVH
`define FULLY_ASSOCIATIVE_LRU_TRACKER_ASSERT_SVH

// Same-cycle implication.
`define FALRU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FALRU_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/falru_pkg.sv
// ----------------------------------------------------------------------------
// falru_pkg
// Shared constants, types and sequencer states of the LRU tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package falru_pkg;

	localparam int CAPACITY   = 16;
	localparam int SLOT_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int BN_W       = 32;
	localparam int LIMIT_W    = 5;
	localparam int OUT_SLOT_W = 4;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

	localparam logic ACT_LOOKUP = 1'b0;
	localparam logic ACT_INSERT = 1'b1;

	typedef logic [SLOT_W-1:0]  slot_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [BN_W-1:0]    bn_t;
	typedef logic [LIMIT_W-1:0] limit_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PROMOTE,
		ST_INSERT,
		ST_RESULT
	} state_t;

	// Recency list update
	typedef struct packed {
		logic  promote;
		logic  append;
		slot_t pos;
		slot_t tail;
	} ord_cmd_t;

	// Block store access
	typedef struct packed {
		logic  rd;
		slot_t rd_slot;
		slot_t rd_pos;
		logic  wr;
		slot_t wr_slot;
	} mem_cmd_t;

	// Compare result of the slot read last cycle
	typedef struct packed {
		logic  vld;
		logic  match;
		slot_t pos;
		slot_t slot;
	} mem_sts_t;

endpackage

>>> sv/falru_order.sv
// ----------------------------------------------------------------------------
// falru_order
// Recency list (LRU at position 0) and fill count of the tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module falru_order (
	input  logic              clk,
	input  logic              arst_n,
	input  falru_pkg::ord_cmd_t cmd,
	input  falru_pkg::slot_t  rd_pos,
	output falru_pkg::slot_t  rd_slot,
	output falru_pkg::slot_t  head,
	output falru_pkg::cnt_t   filled
);
	import falru_pkg::*;

	slot_t order_q [CAPACITY];
	cnt_t  filled_q;

	assign rd_slot = order_q[rd_pos];
	assign head    = order_q[0];
	assign filled  = filled_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
		end else if (cmd.append) begin
			filled_q <= filled_q + CNT_W'(1);
		end
	end

	// Promote: close the gap at pos and place tail at the MRU end.
	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (cmd.promote && (CNT_W'(i) >= CNT_W'(cmd.pos))) begin
				if (CNT_W'(i + 1) < filled_q) begin
					order_q[i] <= order_q[SLOT_W'(i + 1)];
				end else if (CNT_W'(i + 1) == filled_q) begin
					order_q[i] <= cmd.tail;
				end
			end
		end
		if (cmd.append) begin
			order_q[filled_q[SLOT_W-1:0]] <= filled_q[SLOT_W-1:0];
		end
	end

endmodule

>>> sv/falru_match.sv
// ----------------------------------------------------------------------------
// falru_match
// Block number store with registered read and the shared tag comparator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module falru_match (
	input  logic               clk,
	input  logic               arst_n,
	input  falru_pkg::mem_cmd_t cmd,
	input  falru_pkg::bn_t     key,
	output falru_pkg::mem_sts_t sts
);
	import falru_pkg::*;

	bn_t   blocks_mem [CAPACITY];
	bn_t   blk_s1;
	slot_t slot_s1;
	slot_t pos_s1;
	logic  vld_s1;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			blocks_mem[cmd.wr_slot] <= key;
		end
		if (cmd.rd) begin
			blk_s1 <= blocks_mem[cmd.rd_slot];
		end
		slot_s1 <= cmd.rd_slot;
		pos_s1  <= cmd.rd_pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd;
		end
	end

	assign sts.vld   = vld_s1;
	assign sts.match = (blk_s1 == key);
	assign sts.pos   = pos_s1;
	assign sts.slot  = slot_s1;

endmodule

>>> sv/falru_ctrl.sv
// ----------------------------------------------------------------------------
// falru_ctrl
// Sequencer: scans the recency list one position a cycle on a lookup, and updates it on a hit or an insert.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module falru_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  falru_pkg::limit_t   limit,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_action,
	input  falru_pkg::bn_t      in_bn,
	output logic                res_valid,
	input  logic                res_ready,
	output logic                res_hit,
	output falru_pkg::slot_t    res_slot,
	output falru_pkg::slot_t    ord_rd_pos,
	input  falru_pkg::slot_t    ord_rd_slot,
	input  falru_pkg::slot_t    ord_head,
	input  falru_pkg::cnt_t     filled,
	output falru_pkg::ord_cmd_t ocmd,
	output falru_pkg::mem_cmd_t mcmd,
	output falru_pkg::bn_t      key,
	input  falru_pkg::mem_sts_t mst
);
	import falru_pkg::*;
	`include "fully_associative_lru_tracker_assert.svh"

	state_t state_q, state_d;
	cnt_t   pos_q;
	logic   act_q;
	bn_t    bn_q;
	logic   hit_q;
	slot_t  slot_q;
	slot_t  hit_pos_q;
	cnt_t   eff_limit;
	logic   found;
	logic   last;
	logic   room;

	always_comb begin
		if (limit == '0) begin
			eff_limit = CNT_W'(1);
		end else if (32'(limit) > 32'(CAPACITY)) begin
			eff_limit = CNT_W'(CAPACITY);
		end else begin
			eff_limit = CNT_W'(limit);
		end
	end

	assign found      = mst.vld && mst.match;
	assign last       = mst.vld && (CNT_W'(mst.pos) == (filled - CNT_W'(1)));
	assign room       = (filled < eff_limit);
	assign ord_rd_pos = pos_q[SLOT_W-1:0];
	assign key        = bn_q;
	assign res_hit    = hit_q;
	assign res_slot   = slot_q;

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		res_valid    = 1'b0;
		ocmd         = '0;
		mcmd         = '0;
		mcmd.rd_slot = ord_rd_slot;
		mcmd.rd_pos  = pos_q[SLOT_W-1:0];
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_action == ACT_INSERT) begin
						state_d = ST_INSERT;
					end else if (filled == '0) begin
						state_d = ST_RESULT;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				// issue one position a cycle; its compare lands in the next cycle
				mcmd.rd = (pos_q < filled) && !found;
				if (found) begin
					state_d = ST_PROMOTE;
				end else if (last) begin
					state_d = ST_RESULT;
				end
			end
			ST_PROMOTE: begin
				ocmd.promote = 1'b1;
				ocmd.pos     = hit_pos_q;
				ocmd.tail    = slot_q;
				state_d      = ST_RESULT;
			end
			ST_INSERT: begin
				mcmd.wr = 1'b1;
				if (room) begin
					ocmd.append  = 1'b1;
					mcmd.wr_slot = filled[SLOT_W-1:0];
				end else begin
					// overwrite the LRU slot and move it to the MRU end
					ocmd.promote = 1'b1;
					ocmd.pos     = '0;
					ocmd.tail    = ord_head;
					mcmd.wr_slot = ord_head;
				end
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				pos_q <= '0;
			end else if (mcmd.rd) begin
				pos_q <= pos_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_q  <= in_action;
			bn_q   <= in_bn;
			hit_q  <= 1'b0;
			slot_q <= '0;
		end else if (state_q == ST_SCAN && found) begin
			hit_q     <= 1'b1;
			slot_q    <= mst.slot;
			hit_pos_q <= mst.pos;
		end else if (state_q == ST_INSERT) begin
			slot_q <= room ? filled[SLOT_W-1:0] : ord_head;
		end
	end

	`FALRU_ASSERT_IMP(a_fill_bound, 1'b1, filled <= CNT_W'(CAPACITY), "fill count above capacity")
	`FALRU_ASSERT_IMP(a_scan_in_range, state_q == ST_SCAN && mst.vld, CNT_W'(mst.pos) < filled, "scan read beyond fill")
	`FALRU_ASSERT_NXT(a_accept_leaves_idle, in_valid && in_ready, state_q != ST_IDLE, "accepted item did not start")
	`FALRU_ASSERT_NXT(a_insert_one_cycle, state_q == ST_INSERT, state_q == ST_RESULT && act_q == ACT_INSERT, "insert did not finish")
	`FALRU_ASSERT_IMP(a_no_append_full, ocmd.append, filled < CNT_W'(CAPACITY), "append into a full list")

endmodule

>>> sv/fully_associative_lru_tracker.sv
// ----------------------------------------------------------------------------
// fully_associative_lru_tracker
// Fully associative block number store with LRU replacement.
//
//   channel   dir  handshake               payload
//   s_axis    in   s_axis_tvalid/tready    tuser: action, tdata: block_number
//   m_axis    out  m_axis_tvalid/tready    tuser: hit, tdata: slot_touched
//   cfg       in   cfg_we                  cfg_wdata: slots_in_use_limit
//
// An insert passes through ST_INSERT and ST_RESULT to the output register.
// A lookup scans the recency list through one shared 32-bit comparator, one
// position a cycle; a hit then passes through ST_PROMOTE to ST_RESULT, and a
// miss goes to ST_RESULT, without a scan when the list is empty.
// Reset empties the list and sets the limit to 16; the stores need no clear.
// One item is in flight at a time; the output register holds a result while
// m_axis_tready is low and the next item may already be accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fully_associative_lru_tracker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] block_number
	input  logic [0:0]  s_axis_tuser,  // [0] action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [3:0] slot_touched, [7:4] zero
	output logic [0:0]  m_axis_tuser,  // [0] hit
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata
);
	import falru_pkg::*;

	limit_t   limit_q;
	logic     res_valid;
	logic     res_ready;
	logic     res_hit;
	slot_t    res_slot;
	slot_t    ord_rd_pos;
	slot_t    ord_rd_slot;
	slot_t    ord_head;
	cnt_t     filled;
	ord_cmd_t ocmd;
	mem_cmd_t mcmd;
	bn_t      key;
	mem_sts_t mst;
	logic     out_valid_q;
	logic     out_hit_q;
	logic [OUT_SLOT_W-1:0] out_slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	falru_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.limit       (limit_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_action   (s_axis_tuser[0]),
		.in_bn       (s_axis_tdata),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_hit     (res_hit),
		.res_slot    (res_slot),
		.ord_rd_pos  (ord_rd_pos),
		.ord_rd_slot (ord_rd_slot),
		.ord_head    (ord_head),
		.filled      (filled),
		.ocmd        (ocmd),
		.mcmd        (mcmd),
		.key         (key),
		.mst         (mst)
	);

	falru_order u_order (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (ocmd),
		.rd_pos  (ord_rd_pos),
		.rd_slot (ord_rd_slot),
		.head    (ord_head),
		.filled  (filled)
	);

	falru_match u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mcmd),
		.key    (key),
		.sts    (mst)
	);

	// Output register: load when empty or being drained this cycle.
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_hit_q  <= res_hit;
			out_slot_q <= OUT_SLOT_W'(res_slot);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_hit_q;
	assign m_axis_tdata  = {(8 - OUT_SLOT_W)'(0), out_slot_q};

endmodule
